@@ hw/rtl/dogf_pkg.sv @@
`default_nettype none

package dogf_pkg;

    // Field widths of the words on the ports
    localparam int OPCODE_W   = 2;
    localparam int COORD_W    = 7;
    localparam int PIXEL_W    = 8;
    localparam int COEFF_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int FSIZE_W    = 3;
    localparam int DIM_W      = 8;

    // Product of an unsigned pixel and a signed coefficient
    localparam int PROD_W     = PIXEL_W + COEFF_W + 1;
    localparam int FRAC_BITS  = 15;
    localparam int PART_MAX   = 255;

    // Tap counters cover the largest kernel side the parameter range allows
    localparam int TAP_W      = 4;

    // Defaults of the top level parameters
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_FILTER = 7;

    // Register reset values
    localparam logic [FSIZE_W-1:0] FSIZE_RESET  = 3'd3;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 8'd128;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 8'd128;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_COEFF  = 2'd0,
        OP_WRITE_PIXEL = 2'd1,
        OP_QUERY       = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_SIZE  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2
    } cfg_reg_t;

    // Controller to datapath
    typedef struct packed {
        logic             accept;    // input word taken this cycle
        logic             start;     // query taken: capture position, clear sum
        logic             tap_valid; // issue one tap read
        logic [TAP_W-1:0] tap_row;
        logic [TAP_W-1:0] tap_col;
        logic             load_out;  // move finished sum into the result register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [TAP_W-1:0] fsize;     // kernel side in use, already saturated
        logic             pipe_busy; // taps still in flight
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/dogf_if.sv @@
`default_nettype none

interface dogf_req_if;
    logic                               valid;
    logic                               ready;
    logic [dogf_pkg::OPCODE_W-1:0]      opcode;
    logic [dogf_pkg::COORD_W-1:0]       row;
    logic [dogf_pkg::COORD_W-1:0]       col;
    logic [dogf_pkg::PIXEL_W-1:0]       pixel_value;
    logic signed [dogf_pkg::COEFF_W-1:0] coeff_value;

    modport source (output valid, opcode, row, col, pixel_value, coeff_value, input ready);
    modport sink   (input valid, opcode, row, col, pixel_value, coeff_value, output ready);
endinterface

interface dogf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dogf_pkg::COORD_W-1:0]  out_row;
    logic [dogf_pkg::COORD_W-1:0]  out_col;
    logic [dogf_pkg::PIXEL_W-1:0]  on_value;
    logic [dogf_pkg::PIXEL_W-1:0]  off_value;

    modport source (output valid, out_row, out_col, on_value, off_value, input ready);
    modport sink   (input valid, out_row, out_col, on_value, off_value, output ready);
endinterface

interface dogf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dogf_pkg::CFG_IDX_W-1:0]   index;
    logic [dogf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dog_on_off_filter_top.sv @@
`default_nettype none
// Load-coefficient and write-pixel words are stored on acceptance; an out-of-range one is dropped.
// A query walks all fs*fs kernel taps (fs = kernel side in use; a zero side has none), one
// multiply-accumulate per tap through one read port, then loads the result register.
// No word is accepted while a query runs or waits to load its result; a word of any kind,
// a query too, is accepted in any idle cycle, also while a result still waits.
// Reset (rst_n, async, active low) restores the registers and control; stores are not cleared.
module dog_on_off_filter_top #(
    parameter int MAX_HEIGHT = dogf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dogf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FILTER = dogf_pkg::DEF_MAX_FILTER
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dogf_req_if.sink    req,
    dogf_rsp_if.source  rsp,
    dogf_cfg_if.sink    cfg
);
    import dogf_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencer: accepts words, walks the kernel taps, hands off the result
    dogf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_opcode (req.opcode),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Stores, edge clamping, multiply-accumulate, on/off split and the register file
    dogf_datapath #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FILTER (MAX_FILTER)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_opcode (req.opcode),
        .req_row    (req.row),
        .req_col    (req.col),
        .req_pixel  (req.pixel_value),
        .req_coeff  (req.coeff_value),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .cmd        (cmd),
        .status     (status),
        .out_row    (rsp.out_row),
        .out_col    (rsp.out_col),
        .on_value   (rsp.on_value),
        .off_value  (rsp.off_value)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dogf_ctrl.sv @@
`default_nettype none

module dogf_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire logic [dogf_pkg::OPCODE_W-1:0] req_opcode,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    input  wire dogf_pkg::ctrl_status_t  status,
    output dogf_pkg::ctrl_cmd_t          cmd
);
    import dogf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] fr_reg, fr_next;
    logic [TAP_W-1:0] fc_reg, fc_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [TAP_W-1:0] last_tap;
    logic             accept;
    logic             out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign last_tap  = status.fsize - TAP_W'(1);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        fr_next       = fr_reg;
        fc_next       = fc_reg;
        cmd           = '0;
        cmd.accept    = accept;
        cmd.tap_row   = fr_reg;
        cmd.tap_col   = fc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_opcode == OP_QUERY))
                begin
                    cmd.start = 1'b1;
                    fr_next   = '0;
                    fc_next   = '0;
                    // a zero kernel side has no taps: the cleared sum stands
                    state_next = (status.fsize == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.tap_valid = 1'b1;
                if (fc_reg == last_tap)
                begin
                    fc_next = '0;
                    if (fr_reg == last_tap)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        fr_next = fr_reg + TAP_W'(1);
                    end
                end
                else
                begin
                    fc_next = fc_reg + TAP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fr_reg        <= '0;
            fc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fr_reg        <= fr_next;
            fc_reg        <= fc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Never load a result while taps are still in flight
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.pipe_busy)
        else $error("result loaded with taps in flight");

    // Issued taps stay inside the kernel in use
    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_valid |-> (fr_reg < status.fsize) && (fc_reg < status.fsize))
        else $error("tap index beyond kernel side");

    // A result waiting to be taken is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/dogf_datapath.sv @@
`default_nettype none

module dogf_datapath #(
    parameter int MAX_HEIGHT = dogf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dogf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FILTER = dogf_pkg::DEF_MAX_FILTER
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [dogf_pkg::OPCODE_W-1:0]     req_opcode,
    input  wire logic [dogf_pkg::COORD_W-1:0]      req_row,
    input  wire logic [dogf_pkg::COORD_W-1:0]      req_col,
    input  wire logic [dogf_pkg::PIXEL_W-1:0]      req_pixel,
    input  wire logic signed [dogf_pkg::COEFF_W-1:0] req_coeff,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dogf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dogf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire dogf_pkg::ctrl_cmd_t               cmd,
    output dogf_pkg::ctrl_status_t                 status,
    output logic [dogf_pkg::COORD_W-1:0]           out_row,
    output logic [dogf_pkg::COORD_W-1:0]           out_col,
    output logic [dogf_pkg::PIXEL_W-1:0]           on_value,
    output logic [dogf_pkg::PIXEL_W-1:0]           off_value
);
    import dogf_pkg::*;

    localparam int RA_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CA_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KA_W = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
    localparam int FRAME_DEPTH = 2 ** (RA_W + CA_W);
    localparam int KERN_DEPTH  = 2 ** (2 * KA_W);
    localparam int MAX_DIM     = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int DIM_LIM_W   = $clog2(MAX_DIM + 1);
    localparam int LIM_W       = (DIM_LIM_W > 9) ? DIM_LIM_W : 9;
    localparam int ACC_W       = PROD_W + $clog2(MAX_FILTER * MAX_FILTER + 1);
    localparam int SHR_W       = ACC_W - 1 - FRAC_BITS;

    // Configuration registers
    logic [FSIZE_W-1:0] fsize_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   width_reg;

    // Query position
    logic [COORD_W-1:0] qrow_reg;
    logic [COORD_W-1:0] qcol_reg;

    // Tap pipeline
    logic                       s1_valid_reg;
    logic [PIXEL_W-1:0]         frame_q_reg;
    logic signed [COEFF_W-1:0]  kern_q_reg;
    logic                       s2_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    // Result register
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [PIXEL_W-1:0] on_reg;
    logic [PIXEL_W-1:0] off_reg;

    logic [PIXEL_W-1:0]        frame_mem [FRAME_DEPTH];
    logic signed [COEFF_W-1:0] kern_mem  [KERN_DEPTH];

    logic [TAP_W-1:0]   fsize_eff;
    logic [TAP_W-1:0]   half;
    logic [LIM_W-1:0]   height_m1;
    logic [LIM_W-1:0]   width_m1;
    logic [LIM_W-1:0]   src_row;
    logic [LIM_W-1:0]   src_col;
    logic               frame_we;
    logic               kern_we;
    logic [RA_W+CA_W-1:0] frame_waddr;
    logic [RA_W+CA_W-1:0] frame_raddr;
    logic [2*KA_W-1:0]  kern_waddr;
    logic [2*KA_W-1:0]  kern_raddr;
    logic signed [ACC_W-1:0] acc_neg;
    logic [SHR_W-1:0]   on_shr;
    logic [SHR_W-1:0]   off_shr;
    logic [PIXEL_W-1:0] on_sat;
    logic [PIXEL_W-1:0] off_sat;

    // Clamp a window coordinate onto the image: zero below, last line above
    function automatic logic [LIM_W-1:0] edge_pos(
        input logic [COORD_W-1:0] pos,
        input logic [TAP_W-1:0]   tap,
        input logic [TAP_W-1:0]   hlf,
        input logic [LIM_W-1:0]   lim_m1
    );
        logic [LIM_W-1:0] sum;
        logic [LIM_W-1:0] dif;
        sum = LIM_W'(pos) + LIM_W'(tap);
        dif = sum - LIM_W'(hlf);
        if (sum <= LIM_W'(hlf))
        begin
            return '0;
        end
        return (dif < lim_m1) ? dif : lim_m1;
    endfunction

    // Saturate the register views to the parameter range
    assign fsize_eff = (LIM_W'(fsize_reg) > LIM_W'(MAX_FILTER)) ?
                       TAP_W'(MAX_FILTER) : TAP_W'(fsize_reg);
    assign half      = fsize_eff >> 1;

    always_comb
    begin
        if (height_reg == '0)
        begin
            height_m1 = '0;
        end
        else if (LIM_W'(height_reg) > LIM_W'(MAX_HEIGHT))
        begin
            height_m1 = LIM_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            height_m1 = LIM_W'(height_reg) - LIM_W'(1);
        end
        if (width_reg == '0)
        begin
            width_m1 = '0;
        end
        else if (LIM_W'(width_reg) > LIM_W'(MAX_WIDTH))
        begin
            width_m1 = LIM_W'(MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = LIM_W'(width_reg) - LIM_W'(1);
        end
    end

    assign src_row = edge_pos(qrow_reg, cmd.tap_row, half, height_m1);
    assign src_col = edge_pos(qcol_reg, cmd.tap_col, half, width_m1);

    assign frame_raddr = {RA_W'(src_row), CA_W'(src_col)};
    assign kern_raddr  = {KA_W'(cmd.tap_row), KA_W'(cmd.tap_col)};
    assign frame_waddr = {RA_W'(req_row), CA_W'(req_col)};
    assign kern_waddr  = {KA_W'(req_row), KA_W'(req_col)};

    // Drop writes outside the stores
    assign frame_we = cmd.accept && (req_opcode == OP_WRITE_PIXEL) &&
                      (LIM_W'(req_row) < LIM_W'(MAX_HEIGHT)) &&
                      (LIM_W'(req_col) < LIM_W'(MAX_WIDTH));
    assign kern_we  = cmd.accept && (req_opcode == OP_LOAD_COEFF) &&
                      (LIM_W'(req_row) < LIM_W'(MAX_FILTER)) &&
                      (LIM_W'(req_col) < LIM_W'(MAX_FILTER));

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= req_pixel;
        end
        if (cmd.tap_valid)
        begin
            frame_q_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (kern_we)
        begin
            kern_mem[kern_waddr] <= req_coeff;
        end
        if (cmd.tap_valid)
        begin
            kern_q_reg <= kern_mem[kern_raddr];
        end
    end

    // Multiply, then accumulate; a query start clears the sum and captures the position
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= $signed({1'b0, frame_q_reg}) * kern_q_reg;
        end
        if (cmd.start)
        begin
            acc_reg  <= '0;
            qrow_reg <= req_row;
            qcol_reg <= req_col;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Split into on and off parts, shift out the fraction, saturate
    assign acc_neg = -acc_reg;
    assign on_shr  = acc_reg[ACC_W-2:FRAC_BITS];
    assign off_shr = acc_neg[ACC_W-2:FRAC_BITS];

    always_comb
    begin
        on_sat  = '0;
        off_sat = '0;
        if (!acc_reg[ACC_W-1] && (acc_reg != '0))
        begin
            on_sat = (on_shr > SHR_W'(PART_MAX)) ? PIXEL_W'(PART_MAX) : PIXEL_W'(on_shr);
        end
        if (acc_reg[ACC_W-1])
        begin
            off_sat = (off_shr > SHR_W'(PART_MAX)) ? PIXEL_W'(PART_MAX) : PIXEL_W'(off_shr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg <= qrow_reg;
            out_col_reg <= qcol_reg;
            on_reg      <= on_sat;
            off_reg     <= off_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsize_reg    <= FSIZE_RESET;
            height_reg   <= HEIGHT_RESET;
            width_reg    <= WIDTH_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.tap_valid;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FILTER_SIZE:  fsize_reg  <= cfg_data[FSIZE_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    assign cfg_ready        = 1'b1;
    assign status.fsize     = fsize_eff;
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign on_value  = on_reg;
    assign off_value = off_reg;

    // A product enters the sum only after a read of its operands
    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("multiply stage fired without a read");

    // The on and off parts are never both nonzero
    a_parts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (on_sat == '0) || (off_sat == '0))
        else $error("on and off parts both set");

endmodule

`default_nettype wire

@@ tb/sv/tb_dog_on_off_filter_top.sv @@
module tb_dog_on_off_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dogf_pkg::*;

    localparam int MAX_H     = DEF_MAX_HEIGHT;
    localparam int MAX_W     = DEF_MAX_WIDTH;
    localparam int MAX_F     = DEF_MAX_FILTER;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // Opcode and register index that the block must ignore
    localparam logic [OPCODE_W-1:0]  OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    localparam int IDLE_MAX         = 14;
    localparam int SETTLE_CYCLES    = 8;     // lets the last load/write word retire
    localparam int TAIL_CYCLES      = 60;    // longest query walks 7*7 taps
    localparam int HOLD_CYCLES      = 400;
    localparam int BURST_QUERIES    = 10;
    localparam int WORDS_PER_PHASE  = 52;    // words per phase, window fills included
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int PRESSURE_PHASE   = 1;
    localparam int SPARE_REG_PHASE  = 2;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [PIXEL_W-1:0]  pix;
        logic [COEFF_W-1:0]  coeff;
    } dog_word_t;

    // One row of the directed table; on/off typed in only where obvious
    typedef struct packed {
        dog_word_t          word;
        logic               typed;
        logic [PIXEL_W-1:0] on_v;
        logic [PIXEL_W-1:0] off_v;
    } dir_row_t;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIXEL_W-1:0] on_v;
        logic [PIXEL_W-1:0] off_v;
    } dog_resp_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] fsize;
        logic [CFG_DATA_W-1:0] height;
        logic [CFG_DATA_W-1:0] width;
    } dog_setting_t;

    logic clk;
    logic rst_n;

    dogf_req_if req_bus ();
    dogf_rsp_if rsp_bus ();
    dogf_cfg_if cfg_bus ();

    dog_on_off_filter_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Shadow of the frame, the kernel and the registers, plus which entries hold data
    logic [PIXEL_W-1:0]        frame_mem  [MAX_H][MAX_W];
    bit                        pix_loaded [MAX_H][MAX_W];
    logic signed [COEFF_W-1:0] tap_mem    [MAX_F][MAX_F];
    bit                        tap_loaded [MAX_F][MAX_F];
    logic [FSIZE_W-1:0]        fsize_q;
    logic [DIM_W-1:0]          height_q;
    logic [DIM_W-1:0]          width_q;

    dog_resp_t pending_responses [$];

    bit tx_idle;
    bit rx_idle;
    int hold_len;
    int stuck_cycles;
    int err_count;
    int n_queries;
    int n_pixels;
    int n_coeffs;
    int n_dropped;
    int n_checked;
    int n_settings;
    int n_words;

    // Reset config, fs = 3 and a 128x128 plane. Only the center tap is nonzero, so each
    // query below returns the corner pixel times that tap, which reads off directly.
    dir_row_t directed_words [25] = '{
        '{'{OP_LOAD_COEFF,  7'd0,   7'd0,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd0,   7'd1,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd0,   7'd2,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd1,   7'd0,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd1,   7'd1,   8'd0,   16'h7FFF}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd1,   7'd2,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd2,   7'd0,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd2,   7'd1,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd2,   7'd2,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd0,   7'd0,   8'd255, 16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd0,   7'd1,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd1,   7'd0,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd1,   7'd1,   8'd0,   16'h0000}, 1'b0, 8'd0,   8'd0},
        // corner query, edge clamp folds the center tap onto (0,0): 255*32767 >> 15
        '{'{OP_QUERY,       7'd0,   7'd0,   8'd0,   16'h0000}, 1'b1, 8'd254, 8'd0},
        '{'{OP_LOAD_COEFF,  7'd1,   7'd1,   8'd0,   16'h8000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_QUERY,       7'd0,   7'd0,   8'd0,   16'h0000}, 1'b1, 8'd0,   8'd255},
        '{'{OP_WRITE_PIXEL, 7'd126, 7'd126, 8'd170, 16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd126, 7'd127, 8'd85,  16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd127, 7'd126, 8'd1,   16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_WRITE_PIXEL, 7'd127, 7'd127, 8'd128, 16'h0000}, 1'b0, 8'd0,   8'd0},
        '{'{OP_QUERY,       7'd127, 7'd127, 8'd255, 16'hFFFF}, 1'b1, 8'd0,   8'd128},
        // out-of-range taps and the reserved opcode must leave both stores alone
        '{'{OP_LOAD_COEFF,  7'd0,   7'd7,   8'd0,   16'h7FFF}, 1'b0, 8'd0,   8'd0},
        '{'{OP_LOAD_COEFF,  7'd127, 7'd127, 8'd0,   16'h7FFF}, 1'b0, 8'd0,   8'd0},
        '{'{OP_RESERVED,    7'd0,   7'd0,   8'd0,   16'h7FFF}, 1'b0, 8'd0,   8'd0},
        '{'{OP_QUERY,       7'd0,   7'd0,   8'd0,   16'h0000}, 1'b1, 8'd0,   8'd255}
    };

    // Register settings walked after the reset config: fs 8 wraps to 0, fs 0xFF to 7,
    // dimensions 0 act as 1 and anything above 128 saturates
    dog_setting_t settings [8] = '{
        '{8'd1,   8'd128, 8'd128},
        '{8'd7,   8'd12,  8'd10},
        '{8'd8,   8'd0,   8'd0},
        '{8'd4,   8'd200, 8'd1},
        '{8'hFF,  8'd1,   8'd255},
        '{8'd5,   8'd20,  8'd128},
        '{8'd2,   8'd128, 8'd3},
        '{8'd6,   8'd33,  8'd64}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int kernel_side();
        return (int'(fsize_q) > MAX_F) ? MAX_F : int'(fsize_q);
    endfunction

    function automatic int dim_limit(logic [DIM_W-1:0] d, int hi);
        if (d == '0)
            return 1;
        if (int'(d) > hi)
            return hi;
        return int'(d);
    endfunction

    // Source row/column of one tap: window centered on pos, clamped to the plane
    function automatic int src_coord(int pos, int tap, int half, int size);
        int s;
        s = pos + tap;
        if (s <= half)
            return 0;
        return (s - half < size - 1) ? s - half : size - 1;
    endfunction

    function automatic longint dog_window_sum(int row, int col);
        int     fs;
        int     half;
        int     h;
        int     w;
        int     fr;
        int     fc;
        int     sr;
        int     sc;
        longint acc;
        fs   = kernel_side();
        half = fs / 2;
        h    = dim_limit(height_q, MAX_H);
        w    = dim_limit(width_q, MAX_W);
        acc  = 0;
        for (fr = 0; fr < fs; fr++)
        begin
            sr = src_coord(row, fr, half, h);
            for (fc = 0; fc < fs; fc++)
            begin
                sc = src_coord(col, fc, half, w);
                acc += longint'(frame_mem[sr][sc]) * longint'(tap_mem[fr][fc]);
            end
        end
        return acc;
    endfunction

    // Drop the 15 fraction bits (from the Q1.15 taps) of a positive sum and saturate to a pixel
    function automatic logic [PIXEL_W-1:0] response_part(longint v);
        longint m;
        if (v <= 0)
            return '0;
        m = v >>> FRAC_BITS;
        if (m > PART_MAX)
            return PIXEL_W'(PART_MAX);
        return PIXEL_W'(m);
    endfunction

    // Advance the shadow state by one accepted word and queue its response
    task automatic apply_word(dog_word_t w, logic typed, logic [PIXEL_W-1:0] t_on,
                              logic [PIXEL_W-1:0] t_off);
        dog_resp_t resp;
        longint    v;
        case (w.op)
            OP_LOAD_COEFF:
                if (w.row < MAX_F && w.col < MAX_F)
                begin
                    tap_mem[w.row][w.col]    = w.coeff;
                    tap_loaded[w.row][w.col] = 1'b1;
                    n_coeffs++;
                end
                else
                    n_dropped++;
            OP_WRITE_PIXEL:
                if (w.row < MAX_H && w.col < MAX_W)
                begin
                    frame_mem[w.row][w.col]  = w.pix;
                    pix_loaded[w.row][w.col] = 1'b1;
                    n_pixels++;
                end
                else
                    n_dropped++;
            OP_QUERY:
            begin
                v          = dog_window_sum(w.row, w.col);
                resp.row   = w.row;
                resp.col   = w.col;
                resp.on_v  = typed ? t_on : response_part(v);
                resp.off_v = typed ? t_off : response_part(-v);
                pending_responses.push_back(resp);
                n_queries++;
            end
            default:
                n_dropped++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic dog_word_t make_word(logic [OPCODE_W-1:0] op, int row, int col,
                                            int pix, int coeff);
        dog_word_t w;
        w.op    = op;
        w.row   = row[COORD_W-1:0];
        w.col   = col[COORD_W-1:0];
        w.pix   = pix[PIXEL_W-1:0];
        w.coeff = coeff[COEFF_W-1:0];
        return w;
    endfunction

    // Half full-scale, half small taps so responses also land inside the output range
    function automatic int rand_coeff();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, 4095) - 2048;
    endfunction

    // Cluster near both ends of each axis so the frame fills up quickly, reach anywhere now and then
    function automatic int pick_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(0, 15);
        if (sel < 85)
            return $urandom_range(COORD_MAX - 15, COORD_MAX);
        return $urandom_range(0, COORD_MAX);
    endfunction

    // Offer one word after a random gap (none while tx_idle is clear) and hold it until taken
    task automatic send_checked(dog_word_t w, logic typed, logic [PIXEL_W-1:0] t_on,
                                logic [PIXEL_W-1:0] t_off);
        int gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= w.op;
        req_bus.row         <= w.row;
        req_bus.col         <= w.col;
        req_bus.pixel_value <= w.pix;
        req_bus.coeff_value <= w.coeff;
        do
        begin
            @(posedge clk);
        end
        while (!(req_bus.valid && req_bus.ready));
        n_words++;
        apply_word(w, typed, t_on, t_off);
    endtask

    task automatic send_word(dog_word_t w);
        send_checked(w, 1'b0, '0, '0);
    endtask

    // Load every tap and pixel a query at (row,col) will read that holds no data yet
    task automatic fill_window(int row, int col);
        int fs;
        int half;
        int h;
        int w;
        int fr;
        int fc;
        int sr;
        int sc;
        fs   = kernel_side();
        half = fs / 2;
        h    = dim_limit(height_q, MAX_H);
        w    = dim_limit(width_q, MAX_W);
        for (fr = 0; fr < fs; fr++)
        begin
            for (fc = 0; fc < fs; fc++)
            begin
                if (!tap_loaded[fr][fc])
                    send_word(make_word(OP_LOAD_COEFF, fr, fc, $urandom, rand_coeff()));
            end
        end
        for (fr = 0; fr < fs; fr++)
        begin
            sr = src_coord(row, fr, half, h);
            for (fc = 0; fc < fs; fc++)
            begin
                sc = src_coord(col, fc, half, w);
                if (!pix_loaded[sr][sc])
                    send_word(make_word(OP_WRITE_PIXEL, sr, sc, $urandom, $urandom));
            end
        end
    endtask

    task automatic random_word();
        int sel;
        int r;
        int c;
        sel = $urandom_range(0, 99);
        r   = pick_coord();
        c   = pick_coord();
        if (sel < 40)
        begin
            fill_window(r, c);
            send_word(make_word(OP_QUERY, r, c, $urandom, $urandom));
        end
        else if (sel < 75)
            send_word(make_word(OP_WRITE_PIXEL, r, c, $urandom, $urandom));
        else if (sel < 90)
        begin
            // mostly real taps, sometimes far outside the kernel
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COORD_MAX)
                                            : $urandom_range(0, MAX_F - 1);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COORD_MAX)
                                            : $urandom_range(0, MAX_F - 1);
            send_word(make_word(OP_LOAD_COEFF, r, c, $urandom, rand_coeff()));
        end
        else
            send_word(make_word(OP_RESERVED, r, c, $urandom, $urandom));
    endtask

    // Drop valid, wait for every response, then let the last load/write retire
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_bus.valid && cfg_bus.ready));
        case (idx)
            REG_FILTER_SIZE:  fsize_q  = data[FSIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_q = data;
            REG_IMAGE_WIDTH:  width_q  = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(dog_setting_t s, bit with_spare);
        write_reg(REG_FILTER_SIZE, s.fsize);
        write_reg(REG_IMAGE_HEIGHT, s.height);
        if (with_spare)
            write_reg(REG_SPARE, 8'($urandom));
        write_reg(REG_IMAGE_WIDTH, s.width);
        cfg_bus.valid <= 1'b0;
        n_settings++;
    endtask

    // Freeze the output and stream a burst of queries back to back so the input stalls
    task automatic stall_burst();
        int qr [BURST_QUERIES];
        int qc [BURST_QUERIES];
        int k;
        bit saved_idle;
        for (k = 0; k < BURST_QUERIES; k++)
        begin
            qr[k] = $urandom_range(0, COORD_MAX);
            qc[k] = $urandom_range(0, COORD_MAX);
            fill_window(qr[k], qc[k]);
        end
        drain_responses();
        hold_len   = HOLD_CYCLES;
        saved_idle = tx_idle;
        tx_idle    = 1'b0;
        for (k = 0; k < BURST_QUERIES; k++)
            send_word(make_word(OP_QUERY, qr[k], qc[k], $urandom, $urandom));
        tx_idle = saved_idle;
        drain_responses();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        int p;
        int phase_end;

        // drive every input known from time zero
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = '0;
        req_bus.row         = '0;
        req_bus.col         = '0;
        req_bus.pixel_value = '0;
        req_bus.coeff_value = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        fsize_q             = FSIZE_RESET;
        height_q            = HEIGHT_RESET;
        width_q             = WIDTH_RESET;
        tx_idle             = 1'b1;
        rx_idle             = 1'b1;
        hold_len            = 0;
        err_count           = 0;
        n_queries           = 0;
        n_pixels            = 0;
        n_coeffs            = 0;
        n_dropped           = 0;
        n_checked           = 0;
        n_settings          = 1;
        n_words             = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset config
        for (i = 0; i < $size(directed_words); i++)
            send_checked(directed_words[i].word, directed_words[i].typed,
                         directed_words[i].on_v, directed_words[i].off_v);
        phase_end = n_words + WORDS_PER_PHASE;
        while (n_words < phase_end)
            random_word();
        drain_responses();

        // one random phase per register setting; rotate which side runs without gaps
        for (p = 0; p < $size(settings); p++)
        begin
            tx_idle = (p % 3 != 1);
            rx_idle = (p % 3 != 2);
            apply_setting(settings[p], p == SPARE_REG_PHASE);
            phase_end = n_words + WORDS_PER_PHASE;
            while (n_words < phase_end)
                random_word();
            if (p == PRESSURE_PHASE)
                stall_burst();
            drain_responses();
        end

        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d queries over %0d register settings, %0d pixel writes,",
                 n_queries, n_settings, n_pixels);
        $display("%0d tap loads, %0d dropped words and one long output stall; %0d checked",
                 n_coeffs, n_dropped, n_checked);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stalls per word, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        rsp_bus.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
            begin
                stall = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
                if (stall > 0)
                begin
                    rsp_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_bus.valid && rsp_bus.ready) && hold_len == 0);
        end
    end

    // Compare each taken word against the oldest pending response
    always @(posedge clk)
    begin : result_check
        dog_resp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with no query pending", rsp_bus.out_row, -1);
            else
            begin
                want = pending_responses.pop_front();
                n_checked++;
                if (rsp_bus.out_row !== want.row)
                    report_mismatch("out_row", rsp_bus.out_row, want.row);
                if (rsp_bus.out_col !== want.col)
                    report_mismatch("out_col", rsp_bus.out_col, want.col);
                if (rsp_bus.on_value !== want.on_v)
                    report_mismatch("on_value", rsp_bus.on_value, want.on_v);
                if (rsp_bus.off_value !== want.off_v)
                    report_mismatch("off_value", rsp_bus.off_value, want.off_v);
            end
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles, %0d responses pending",
                     $time, stuck_cycles, pending_responses.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
